@@ rtl/core/tree_bitmap_range_set_clear_unit_assert.svh @@
// ----------------------------------------------------------------------------
// tree bitmap range set/clear unit assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef TREE_BITMAP_RANGE_SET_CLEAR_UNIT_ASSERT_SVH
`define TREE_BITMAP_RANGE_SET_CLEAR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define TBRSC_ASSERT_CR(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TBRSC_ASSERT(name, prop, msg) \
  `TBRSC_ASSERT_CR(name, clk_i, rst_ni, prop, msg)
`else
`define TBRSC_ASSERT_CR(name, clk, rst_n, prop, msg)
`define TBRSC_ASSERT(name, prop, msg)
`endif

`endif

@@ rtl/core/tbrsc_pkg.sv @@
// ----------------------------------------------------------------------------
// tbrsc_pkg
// shared widths, codes and state type of the tree bitmap range set/clear unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbrsc_pkg;

  localparam int unsigned ActionW     = 2;
  localparam int unsigned FirstNodeW  = 10;
  localparam int unsigned RangeLenW   = 11;
  localparam int unsigned TreeSizeW   = 11;
  localparam int unsigned DefMaxNodes = 1024;

  localparam logic [TreeSizeW-1:0] TreeSizeRst = 11'd1024;

  typedef enum logic [ActionW-1:0] {
    ACT_SET   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2
  } act_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NEXT,
    ST_FD_RD,
    ST_FD_EV,
    ST_FD_ADV,
    ST_FU_CK,
    ST_FU_EV,
    ST_ED_RD,
    ST_ED_EV,
    ST_ED_PATH,
    ST_EU_CK,
    ST_EU_EV,
    ST_RD_EV,
    ST_DONE
  } st_e;

endpackage

@@ rtl/core/tbrsc_if.sv @@
// ----------------------------------------------------------------------------
// tbrsc channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tbrsc_req_if import tbrsc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ActionW-1:0]    action;
  logic [FirstNodeW-1:0] first_node;
  logic [RangeLenW-1:0]  range_length;

  modport source (output valid, action, first_node, range_length, input ready);
  modport sink   (input valid, action, first_node, range_length, output ready);
endinterface

interface tbrsc_rsp_if import tbrsc_pkg::*; ();
  logic valid;
  logic ready;
  logic node_value;

  modport source (output valid, node_value, input ready);
  modport sink   (input valid, node_value, output ready);
endinterface

@@ rtl/core/tree_bitmap_range_set_clear_unit.sv @@
// ----------------------------------------------------------------------------
// tree bitmap range set/clear unit
// Keeps a heap-ordered binary tree of one-bit nodes in which a node is 1 when
// its whole subtree is 1. A request transaction on req_i carries an action
// (set range, clear range, read node), a first node and a range length; each
// request gives exactly one response transaction on rsp_o with node_value
// (the read bit, 0 otherwise). cfg_we_i/cfg_wdata_i write the tree size; the
// user must write it only while the unit is idle, as the block itself does not
// enforce this. Sizes above MaxNodes saturate. Requests are served one at a time.
// A read registers the node bit, then passes through ST_RD_EV and ST_DONE to the
// output register. Set and clear walk the node memory one access at a time,
// reading and writing nodes along the subtree and ancestor walks of each index
// in the range.
// After reset the node memory is zeroed by a sweep over all MaxNodes nodes,
// during which req_i.ready stays low; config writes are taken meanwhile.
// A finished response waits in an output register while the next request is
// accepted; the unit stalls at the end of that request until rsp_o drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "tree_bitmap_range_set_clear_unit_assert.svh"

module tree_bitmap_range_set_clear_unit import tbrsc_pkg::*; #(
  parameter int unsigned MaxNodes = DefMaxNodes
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [TreeSizeW-1:0] cfg_wdata_i,
  tbrsc_req_if.sink            req_i,
  tbrsc_rsp_if.source          rsp_o
);

  localparam int unsigned AW = $clog2(MaxNodes);
  localparam int unsigned XW = (AW + 2 > 12) ? AW + 2 : 12;

  logic [TreeSizeW-1:0] tree_size_q;
  st_e                  state_q, state_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic [XW-1:0]        i_q, i_d;
  logic [XW-1:0]        end_q, end_d;
  logic [XW-1:0]        cur_q, cur_d;
  logic [XW-1:0]        pos_q, pos_d;
  logic [ActionW-1:0]   act_q, act_d;
  logic                 result_q, result_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_value_q, out_value_d;

  logic                 node_mem_q [MaxNodes];
  logic                 mem_rdata_q;
  logic                 mem_we, mem_wdata, mem_re;
  logic [XW-1:0]        wr_idx, rd_idx;
  logic [AW-1:0]        mem_waddr, mem_raddr;

  logic [XW-1:0]        n_x, first_x, range_end, req_end;
  logic [XW-1:0]        cur_child, cur_next, cur_par, pos_sib, pos_par;

  // live node count and request range end
  assign n_x       = (32'(tree_size_q) > MaxNodes) ? XW'(MaxNodes) : XW'(tree_size_q);
  assign first_x   = XW'(req_i.first_node);
  assign range_end = first_x + XW'(req_i.range_length);
  assign req_end   = (range_end > n_x) ? n_x : range_end;

  // heap index arithmetic
  assign cur_child = {cur_q[XW-2:0], 1'b1};
  assign cur_next  = cur_q + XW'(1);
  assign cur_par   = (cur_q - XW'(1)) >> 1;
  assign pos_sib   = pos_q[0] ? pos_q + XW'(1) : pos_q - XW'(1);
  assign pos_par   = (pos_q - XW'(1)) >> 1;

  assign mem_waddr = wr_idx[AW-1:0];
  assign mem_raddr = rd_idx[AW-1:0];

  assign req_i.ready      = (state_q == ST_IDLE);
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.node_value = out_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tree_size_q <= TreeSizeRst;
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tree_size_q <= cfg_wdata_i;
      end
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q         <= i_d;
    end_q       <= end_d;
    cur_q       <= cur_d;
    pos_q       <= pos_d;
    act_q       <= act_d;
    result_q    <= result_d;
    out_value_q <= out_value_d;
  end

  // node store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      node_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= node_mem_q[mem_raddr];
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    i_d         = i_q;
    end_d       = end_q;
    cur_d       = cur_q;
    pos_d       = pos_q;
    act_d       = act_q;
    result_d    = result_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    mem_we      = 1'b0;
    mem_wdata   = 1'b0;
    wr_idx      = '0;
    mem_re      = 1'b0;
    rd_idx      = '0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        wr_idx = XW'(clr_q);
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(MaxNodes - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          act_d    = req_i.action;
          i_d      = first_x;
          end_d    = req_end;
          result_d = 1'b0;
          unique case (req_i.action) inside
            ACT_SET, ACT_CLEAR: begin
              state_d = ST_NEXT;
            end
            ACT_READ: begin
              if (first_x < n_x) begin
                mem_re  = 1'b1;
                rd_idx  = first_x;
                state_d = ST_RD_EV;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_NEXT: begin
        if (i_q < end_q) begin
          cur_d = i_q;
          pos_d = i_q;
          if (act_q == ACT_SET) begin
            state_d = ST_FD_RD;
          end else begin
            state_d = ST_ED_RD;
          end
        end else begin
          state_d = ST_DONE;
        end
      end
      // subtree fill, preorder walk through nodes that were 0
      ST_FD_RD: begin
        mem_re  = 1'b1;
        rd_idx  = cur_q;
        state_d = ST_FD_EV;
      end
      ST_FD_EV: begin
        if (mem_rdata_q) begin
          state_d = (cur_q == i_q) ? ST_FU_CK : ST_FD_ADV;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = 1'b1;
          wr_idx    = cur_q;
          if (cur_child < n_x) begin
            cur_d   = cur_child;
            state_d = ST_FD_RD;
          end else begin
            state_d = ST_FD_ADV;
          end
        end
      end
      ST_FD_ADV: begin
        if (cur_q == i_q) begin
          state_d = ST_FU_CK;
        end else if (cur_q[0] && (cur_next < n_x)) begin
          cur_d   = cur_next;
          state_d = ST_FD_RD;
        end else begin
          cur_d = cur_par;
        end
      end
      // ancestor fill while the sibling is set
      ST_FU_CK: begin
        if (pos_q == '0) begin
          i_d     = i_q + XW'(1);
          state_d = ST_NEXT;
        end else if (pos_sib >= n_x) begin
          mem_we    = 1'b1;
          mem_wdata = 1'b1;
          wr_idx    = pos_par;
          pos_d     = pos_par;
        end else begin
          mem_re  = 1'b1;
          rd_idx  = pos_sib;
          state_d = ST_FU_EV;
        end
      end
      ST_FU_EV: begin
        if (!mem_rdata_q) begin
          i_d     = i_q + XW'(1);
          state_d = ST_NEXT;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = 1'b1;
          wr_idx    = pos_par;
          pos_d     = pos_par;
          state_d   = ST_FU_CK;
        end
      end
      // node clear and leftmost descendant path
      ST_ED_RD: begin
        mem_re  = 1'b1;
        rd_idx  = i_q;
        state_d = ST_ED_EV;
      end
      ST_ED_EV: begin
        if (mem_rdata_q) begin
          mem_we  = 1'b1;
          wr_idx  = i_q;
          cur_d   = cur_child;
          state_d = ST_ED_PATH;
        end else begin
          state_d = ST_EU_CK;
        end
      end
      ST_ED_PATH: begin
        if (cur_q < n_x) begin
          mem_we = 1'b1;
          wr_idx = cur_q;
          cur_d  = cur_child;
        end else begin
          state_d = ST_EU_CK;
        end
      end
      // ancestor clear up to the first cleared one
      ST_EU_CK: begin
        if (pos_q == '0) begin
          i_d     = i_q + XW'(1);
          state_d = ST_NEXT;
        end else begin
          mem_re  = 1'b1;
          rd_idx  = pos_par;
          state_d = ST_EU_EV;
        end
      end
      ST_EU_EV: begin
        if (!mem_rdata_q) begin
          i_d     = i_q + XW'(1);
          state_d = ST_NEXT;
        end else begin
          mem_we  = 1'b1;
          wr_idx  = pos_par;
          pos_d   = pos_par;
          state_d = ST_EU_CK;
        end
      end
      ST_RD_EV: begin
        result_d = mem_rdata_q;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_value_d = result_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `TBRSC_ASSERT(a_no_rw_collision, mem_we && mem_re |-> mem_waddr != mem_raddr, "rw collision")
  `TBRSC_ASSERT(a_write_in_bounds, mem_we |-> wr_idx < XW'(MaxNodes), "write out of range")
  `TBRSC_ASSERT(a_done_loads_out, state_q == ST_DONE && !out_valid_q |=> out_valid_q, "done stuck")
  `TBRSC_ASSERT(a_accept_leaves_idle, req_i.valid && req_i.ready |=> state_q != ST_IDLE, "no start")

endmodule
